/* rtl/ubps_pkg.sv */
// Shared types, constants and codes for the buffered UART port service.
// Used by every module of the block but the RAM; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ubps_pkg;

    // Ring sizing and burst limit.
    localparam int QUEUE_DEPTH = 1024;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int MAX_BURST   = 16;
    localparam int CNT_W       = $clog2(MAX_BURST + 1);
    localparam int BURST_W     = 5;
    localparam int BURST_RESET = 16;

    // 16550 status bit groups.
    localparam logic [7:0] LSR_OE     = 8'h02;
    localparam logic [7:0] LSR_ERRORS = 8'h1E;
    localparam logic [7:0] MSR_READY  = 8'hB0;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Operation codes of an input beat.
    typedef enum logic [2:0] {
        OP_RX_BYTE    = 3'd0,
        OP_TX_READY   = 3'd1,
        OP_HOST_WRITE = 3'd2,
        OP_HOST_READ  = 3'd3,
        OP_MODEM_STAT = 3'd4,
        OP_LINE_STAT  = 3'd5,
        OP_CLEAR      = 3'd6
    } op_t;

    // Result kinds of an output beat.
    typedef enum logic [3:0] {
        KIND_ACCEPTED   = 4'd0,
        KIND_READ       = 4'd1,
        KIND_NODATA     = 4'd2,
        KIND_LINE_ERR   = 4'd3,
        KIND_MODEM_ERR  = 4'd4,
        KIND_TX_BYTE    = 4'd5,
        KIND_TX_IDLE    = 4'd6,
        KIND_WRITE_FULL = 4'd7,
        KIND_OVERRUN    = 4'd8
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RX_READ,
        ST_TX_READ,
        ST_EMIT
    } state_t;

    // Flags from the shared pointer unit.
    typedef struct packed {
        ptr_t next;    // a advanced by one, with wrap
        logic eq;      // a == b
        logic adv_eq;  // advanced a == b
    } ptr_flags_t;

endpackage

`default_nettype wire

/* rtl/ubps_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module ubps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/ubps_ptr_unit.sv */
// Shared ring pointer unit: advance with wrap and the two compares.
// Depends on ubps_pkg for the pointer type and flag struct.
`timescale 1ns / 1ps
`default_nettype none

module ubps_ptr_unit (
    input  wire ubps_pkg::ptr_t     a,
    input  wire ubps_pkg::ptr_t     b,
    output ubps_pkg::ptr_flags_t    flags
);

    import ubps_pkg::*;

    localparam ptr_t LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    ptr_t next_ptr;

    // Advance by one and wrap at the end of the ring.
    always_comb
    begin
        if (a == LAST_PTR)
        begin
            next_ptr = '0;
        end
        else
        begin
            next_ptr = a + ptr_t'(1);
        end
    end

    assign flags.next   = next_ptr;
    assign flags.eq     = (a == b);
    assign flags.adv_eq = (next_ptr == b);

endmodule

`default_nettype wire

/* rtl/uart_buffered_port_service.sv */
// Top level of the buffered UART port service: sequencer, status state and rings.
// Depends on ubps_pkg, ubps_ram and ubps_ptr_unit.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | to block  | in_valid / in_stall   | operation, data_byte, status_bits
//  out     | from block| out_valid / out_stall | result_kind, out_byte, last
//  cfg     | to block  | cfg_we                | cfg_wdata (tx_burst)
//
// A result passes the exec and emit states on its way to the output register; a host read
// that returns a byte also passes the receive-read state. Each burst byte is fetched in the
// transmit-read state and loaded in the emit state, set by the ring RAM's registered read
// and the one pointer unit. The next beat is taken in idle after the last result is loaded,
// even while that result still waits in the output register.
// Reset clears pointers, status and control; the ring RAMs hold undefined data and need
// no clearing pass. A stalled output holds the sequencer in its emit state.
`timescale 1ns / 1ps
`default_nettype none

module uart_buffered_port_service (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] operation,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] status_bits,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      result_kind,
    output logic [7:0]      out_byte,
    output logic            last,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata
);

    import ubps_pkg::*;

    // Control and status registers.
    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [7:0]           data_reg;
    logic [7:0]           stat_reg;
    ptr_t                 rx_head_reg, rx_head_next;
    ptr_t                 rx_tail_reg, rx_tail_next;
    ptr_t                 tx_head_reg, tx_head_next;
    ptr_t                 tx_tail_reg, tx_tail_next;
    logic [7:0]           line_status_reg, line_status_next;
    logic [7:0]           modem_status_reg, modem_status_next;
    logic                 pending_reg, pending_next;
    logic [BURST_W-1:0]   burst_reg;
    cnt_t                 cnt_reg, cnt_next;
    kind_t                res_kind_reg, res_kind_next;
    logic [7:0]           res_byte_reg, res_byte_next;
    logic                 res_last_reg, res_last_next;
    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    // Datapath signals.
    ptr_t                 unit_a, unit_b;
    ptr_flags_t           flags;
    logic                 rx_we, rx_re, tx_we, tx_re;
    ptr_t                 tx_raddr;
    logic [7:0]           rx_rdata, tx_rdata;
    logic                 out_load;
    logic                 in_take;
    cnt_t                 limit;
    cnt_t                 cnt_inc;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign out_byte    = out_byte_reg;
    assign last        = out_last_reg;
    assign cnt_inc     = cnt_reg + cnt_t'(1);

    // Effective burst length: zero acts as one, values past the limit clamp.
    always_comb
    begin
        if (burst_reg == '0)
        begin
            limit = cnt_t'(1);
        end
        else if (int'(burst_reg) > MAX_BURST)
        begin
            limit = cnt_t'(MAX_BURST);
        end
        else
        begin
            limit = cnt_t'(burst_reg);
        end
    end

    // The one pointer unit shared by every ring operation.
    ubps_ptr_unit u_ptr (
        .a     (unit_a),
        .b     (unit_b),
        .flags (flags)
    );

    // Receive and transmit rings.
    ubps_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (data_reg),
        .re    (rx_re),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    ubps_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (data_reg),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // Sequencer: next state, ring and status updates, result staging.
    always_comb
    begin
        state_next        = state_reg;
        rx_head_next      = rx_head_reg;
        rx_tail_next      = rx_tail_reg;
        tx_head_next      = tx_head_reg;
        tx_tail_next      = tx_tail_reg;
        line_status_next  = line_status_reg;
        modem_status_next = modem_status_reg;
        pending_next      = pending_reg;
        cnt_next          = cnt_reg;
        res_kind_next     = res_kind_reg;
        res_byte_next     = res_byte_reg;
        res_last_next     = res_last_reg;
        unit_a            = tx_tail_reg;
        unit_b            = tx_head_reg;
        rx_we             = 1'b0;
        rx_re             = 1'b0;
        tx_we             = 1'b0;
        tx_re             = 1'b0;
        tx_raddr          = tx_tail_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_byte_next = '0;
                res_last_next = 1'b1;
                state_next    = ST_EMIT;
                case (op_reg)
                    OP_RX_BYTE:
                    begin
                        unit_a = rx_head_reg;
                        unit_b = rx_tail_reg;
                        if (flags.adv_eq)
                        begin
                            line_status_next = line_status_reg | LSR_OE;
                            pending_next     = 1'b1;
                            res_kind_next    = KIND_OVERRUN;
                        end
                        else
                        begin
                            rx_we         = 1'b1;
                            rx_head_next  = flags.next;
                            res_kind_next = KIND_ACCEPTED;
                        end
                    end
                    OP_HOST_WRITE:
                    begin
                        unit_a = tx_head_reg;
                        unit_b = tx_tail_reg;
                        if (flags.adv_eq)
                        begin
                            res_kind_next = KIND_WRITE_FULL;
                        end
                        else
                        begin
                            tx_we         = 1'b1;
                            tx_head_next  = flags.next;
                            res_kind_next = KIND_ACCEPTED;
                        end
                    end
                    OP_TX_READY:
                    begin
                        unit_a   = tx_tail_reg;
                        unit_b   = tx_head_reg;
                        cnt_next = '0;
                        if (flags.eq)
                        begin
                            res_kind_next = KIND_TX_IDLE;
                        end
                        else
                        begin
                            tx_re      = 1'b1;
                            state_next = ST_TX_READ;
                        end
                    end
                    OP_HOST_READ:
                    begin
                        unit_a       = rx_tail_reg;
                        unit_b       = rx_head_reg;
                        pending_next = 1'b0;
                        if (pending_reg && ((modem_status_reg & MSR_READY) != MSR_READY))
                        begin
                            res_kind_next = KIND_MODEM_ERR;
                        end
                        else if (pending_reg && ((line_status_reg & LSR_ERRORS) != 8'h00))
                        begin
                            res_kind_next = KIND_LINE_ERR;
                        end
                        else if (flags.eq)
                        begin
                            res_kind_next = KIND_NODATA;
                        end
                        else
                        begin
                            rx_re      = 1'b1;
                            state_next = ST_RX_READ;
                        end
                    end
                    OP_MODEM_STAT:
                    begin
                        modem_status_next = stat_reg;
                        pending_next      = 1'b1;
                        res_kind_next     = KIND_ACCEPTED;
                    end
                    OP_LINE_STAT:
                    begin
                        line_status_next = stat_reg;
                        pending_next     = 1'b1;
                        res_kind_next    = KIND_ACCEPTED;
                    end
                    OP_CLEAR:
                    begin
                        rx_head_next  = '0;
                        rx_tail_next  = '0;
                        tx_head_next  = '0;
                        tx_tail_next  = '0;
                        res_kind_next = KIND_ACCEPTED;
                    end
                    default:
                    begin
                        // The unused operation code produces no result.
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_RX_READ:
            begin
                unit_a        = rx_tail_reg;
                unit_b        = rx_head_reg;
                rx_tail_next  = flags.next;
                res_kind_next = KIND_READ;
                res_byte_next = rx_rdata;
                res_last_next = 1'b1;
                state_next    = ST_EMIT;
            end

            ST_TX_READ:
            begin
                unit_a        = tx_tail_reg;
                unit_b        = tx_head_reg;
                tx_tail_next  = flags.next;
                cnt_next      = cnt_inc;
                res_kind_next = KIND_TX_BYTE;
                res_byte_next = tx_rdata;
                res_last_next = flags.adv_eq || (cnt_inc >= limit);
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_load)
                begin
                    if (res_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Fetch the next byte of the burst from the updated tail.
                        tx_re      = 1'b1;
                        state_next = ST_TX_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Ring pointers, status, burst setting and burst counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg      <= '0;
            rx_tail_reg      <= '0;
            tx_head_reg      <= '0;
            tx_tail_reg      <= '0;
            line_status_reg  <= '0;
            modem_status_reg <= '0;
            pending_reg      <= 1'b0;
            burst_reg        <= BURST_W'(BURST_RESET);
            cnt_reg          <= '0;
        end
        else
        begin
            rx_head_reg      <= rx_head_next;
            rx_tail_reg      <= rx_tail_next;
            tx_head_reg      <= tx_head_next;
            tx_tail_reg      <= tx_tail_next;
            line_status_reg  <= line_status_next;
            modem_status_reg <= modem_status_next;
            pending_reg      <= pending_next;
            cnt_reg          <= cnt_next;
            if (cfg_we)
            begin
                burst_reg <= cfg_wdata;
            end
        end
    end

    // Input beat capture and staged result; payload only.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= op_t'(operation);
            data_reg <= data_byte;
            stat_reg <= status_bits;
        end
        res_kind_reg <= res_kind_next;
        res_byte_reg <= res_byte_next;
        res_last_reg <= res_last_next;
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= res_kind_reg;
            out_byte_reg <= res_byte_reg;
            out_last_reg <= res_last_reg;
        end
    end

    // While a burst byte is fetched, the counter is below the effective burst length.
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TX_READ) |-> (cnt_reg < limit))
        else $error("burst counter exceeds burst length");

    // Pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(rx_head_reg) < QUEUE_DEPTH) && (int'(rx_tail_reg) < QUEUE_DEPTH) &&
        (int'(tx_head_reg) < QUEUE_DEPTH) && (int'(tx_tail_reg) < QUEUE_DEPTH))
        else $error("ring pointer out of range");

    // An accepted beat is executed in the following cycle.
    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    // Transmitted bytes only come out of a transmitter-ready event.
    a_tx_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_kind_reg == KIND_TX_BYTE)) |-> (op_reg == OP_TX_READY))
        else $error("tx byte emitted outside a tx ready event");

    // A ring write never lands on a full ring.
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_we || tx_we) |-> !flags.adv_eq)
        else $error("write into a full ring");

endmodule

`default_nettype wire

/* tb/sv/uart_buffered_port_service_tb.sv */
// Testbench for the buffered UART port service: drives events with random beat gaps
// and output stalls, predicts every result beat in a scoreboard class and checks them.
// Depends on ubps_pkg and the uart_buffered_port_service RTL.
`timescale 1ns / 1ps

module uart_buffered_port_service_tb;

    import ubps_pkg::*;

    // Operation code that the block ignores.
    localparam logic [2:0] OP_UNUSED = 3'd7;
    // Cycles left for the block to finish an event that gives no result.
    localparam int         SETTLE_CYCLES = 128;
    localparam longint     TIMEOUT_NS = 64'd240_000_000;
    localparam int         RING_ROOM = QUEUE_DEPTH - 1;

    // Scoreboard: mirrors the rings and status, and holds the awaited result beats.
    class uart_port_scoreboard;

        typedef struct {
            kind_t      kind;
            logic [7:0] value;
            logic       fin;
        } result_t;

        result_t            awaited[$];
        logic [7:0]         rx_ring[$];
        logic [7:0]         tx_ring[$];
        logic [7:0]         line_status;
        logic [7:0]         modem_status;
        bit                 status_pending;
        logic [BURST_W-1:0] burst;
        int                 failures;

        function new();
            line_status    = '0;
            modem_status   = '0;
            status_pending = 1'b0;
            burst          = BURST_W'(BURST_RESET);
            failures       = 0;
        endfunction

        function void set_burst(logic [BURST_W-1:0] value);
            burst = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void await_beat(kind_t kind, logic [7:0] value, logic fin);
            result_t r;
            r.kind  = kind;
            r.value = value;
            r.fin   = fin;
            awaited.push_back(r);
        endfunction

        // Work out the result beats of one accepted event.
        function void note_input(logic [2:0] op, logic [7:0] data, logic [7:0] stat);
            int         limit;
            int         sent;
            logic [7:0] b;
            bit         flagged;
            kind_t      rk;
            flagged = 1'b0;
            rk      = KIND_ACCEPTED;
            case (op)
                OP_RX_BYTE:
                begin
                    if (rx_ring.size() >= RING_ROOM)
                    begin
                        line_status    = line_status | LSR_OE;
                        status_pending = 1'b1;
                        await_beat(KIND_OVERRUN, 8'h00, 1'b1);
                    end
                    else
                    begin
                        rx_ring.push_back(data);
                        await_beat(KIND_ACCEPTED, 8'h00, 1'b1);
                    end
                end
                OP_TX_READY:
                begin
                    limit = (burst == 0) ? 1 : ((burst > MAX_BURST) ? MAX_BURST : int'(burst));
                    if (tx_ring.size() == 0)
                    begin
                        await_beat(KIND_TX_IDLE, 8'h00, 1'b1);
                    end
                    else
                    begin
                        sent = 0;
                        while (tx_ring.size() != 0 && sent < limit)
                        begin
                            b = tx_ring.pop_front();
                            sent++;
                            await_beat(KIND_TX_BYTE, b, (tx_ring.size() == 0) || (sent == limit));
                        end
                    end
                end
                OP_HOST_WRITE:
                begin
                    if (tx_ring.size() >= RING_ROOM)
                    begin
                        await_beat(KIND_WRITE_FULL, 8'h00, 1'b1);
                    end
                    else
                    begin
                        tx_ring.push_back(data);
                        await_beat(KIND_ACCEPTED, 8'h00, 1'b1);
                    end
                end
                OP_HOST_READ:
                begin
                    // Pending status is reported first; a modem error overrides a line error.
                    if (status_pending)
                    begin
                        status_pending = 1'b0;
                        if ((line_status & LSR_ERRORS) != 8'h00)
                        begin
                            rk      = KIND_LINE_ERR;
                            flagged = 1'b1;
                        end
                        if ((modem_status & MSR_READY) != MSR_READY)
                        begin
                            rk      = KIND_MODEM_ERR;
                            flagged = 1'b1;
                        end
                    end
                    if (flagged)
                        await_beat(rk, 8'h00, 1'b1);
                    else if (rx_ring.size() == 0)
                        await_beat(KIND_NODATA, 8'h00, 1'b1);
                    else
                        await_beat(KIND_READ, rx_ring.pop_front(), 1'b1);
                end
                OP_MODEM_STAT:
                begin
                    modem_status   = stat;
                    status_pending = 1'b1;
                    await_beat(KIND_ACCEPTED, 8'h00, 1'b1);
                end
                OP_LINE_STAT:
                begin
                    line_status    = stat;
                    status_pending = 1'b1;
                    await_beat(KIND_ACCEPTED, 8'h00, 1'b1);
                end
                OP_CLEAR:
                begin
                    rx_ring.delete();
                    tx_ring.delete();
                    await_beat(KIND_ACCEPTED, 8'h00, 1'b1);
                end
                default:
                begin
                    // The unused code is dropped without a result.
                end
            endcase
        endfunction

        // Compare one accepted result beat with the oldest awaited one.
        function void check_result(logic [3:0] kind, logic [7:0] value, logic fin);
            result_t r;
            if (awaited.size() == 0)
            begin
                $error("result beat with none awaited: result_kind %0d out_byte 0x%02h last %0d",
                       kind, value, fin);
                failures++;
                return;
            end
            r = awaited.pop_front();
            if (kind !== r.kind)
            begin
                $error("result_kind: expected %0d, actual %0d", r.kind, kind);
                failures++;
            end
            if (value !== r.value)
            begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", r.value, value);
                failures++;
            end
            if (fin !== r.fin)
            begin
                $error("last: expected %0d, actual %0d", r.fin, fin);
                failures++;
            end
        endfunction

    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [2:0]          operation;
    logic [7:0]          data_byte;
    logic [7:0]          status_bits;
    logic                out_valid;
    logic                out_stall;
    logic [3:0]          result_kind;
    logic [7:0]          out_byte;
    logic                out_last;
    logic                cfg_we;
    logic [BURST_W-1:0]  cfg_wdata;

    uart_port_scoreboard sb = new();
    bit                  gaps_on = 1'b1;
    int                  stall_run = 0;

    uart_buffered_port_service dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .data_byte   (data_byte),
        .status_bits (status_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .out_byte    (out_byte),
        .last        (out_last),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output stall: runs of no stalling, short stalls and a few long ones.
    always @(posedge clk)
    begin
        int r;
        if (stall_run == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                out_stall <= 1'b0;
                stall_run = $urandom_range(0, 39);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(0, 2);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b0;
                stall_run = $urandom_range(0, 4);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(9, 39);
            end
        end
        else
        begin
            stall_run--;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_kind, out_byte, out_last);
    end

    // Hard limit on the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Idle cycles between input beats: mostly none or a few, rarely many.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // Present one beat, wait for it to be taken, then maybe idle with junk on the payload.
    task automatic send_beat(logic [2:0] op, logic [7:0] data, logic [7:0] stat);
        int gap;
        in_valid    <= 1'b1;
        operation   <= op;
        data_byte   <= data;
        status_bits <= stat;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(op, data, stat);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid    <= 1'b0;
            operation   <= 3'($urandom);
            data_byte   <= 8'($urandom);
            status_bits <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] data);
        send_beat(op, data, 8'($urandom));
    endtask

    task automatic send_status(logic [2:0] op, logic [7:0] stat);
        send_beat(op, 8'($urandom), stat);
    endtask

    // Stop sending, let every awaited beat arrive and give the block time to go idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_burst(logic [BURST_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_burst(value);
    endtask

    // Random traffic: mostly well-formed events, some status churn, clears and junk codes.
    task automatic run_random(int count);
        int         done;
        int         r;
        logic [2:0] op;
        logic [7:0] stat;
        done = 0;
        while (done < count)
        begin
            if (done % 40 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 22)
                op = OP_RX_BYTE;
            else if (r < 44)
                op = OP_HOST_READ;
            else if (r < 64)
                op = OP_HOST_WRITE;
            else if (r < 76)
                op = OP_TX_READY;
            else if (r < 82)
                op = OP_MODEM_STAT;
            else if (r < 88)
                op = OP_LINE_STAT;
            else if (r < 91)
                op = OP_CLEAR;
            else if (r < 93)
                op = OP_UNUSED;
            else
                op = OP_RX_BYTE;
            stat = 8'($urandom);
            if (op == OP_MODEM_STAT && $urandom_range(0, 3) != 0)
                stat = stat | MSR_READY;
            if (op == OP_LINE_STAT && $urandom_range(0, 1) != 0)
                stat = stat & ~LSR_ERRORS;
            send_beat(op, 8'($urandom), stat);
            if (op != OP_UNUSED)
                done++;
        end
        gaps_on = 1'b1;
    endtask

    // Main sequence.
    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        operation   <= OP_RX_BYTE;
        data_byte   <= 8'h00;
        status_bits <= 8'h00;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty rings, byte extremes, every status path, junk code and clear.
        send_op(OP_HOST_READ, 8'h00);
        send_op(OP_TX_READY, 8'h00);
        send_op(OP_RX_BYTE, 8'h00);
        send_op(OP_RX_BYTE, 8'hFF);
        send_op(OP_HOST_READ, 8'h00);
        send_op(OP_HOST_READ, 8'h00);
        send_op(OP_HOST_READ, 8'h00);
        send_op(OP_HOST_WRITE, 8'h00);
        send_op(OP_HOST_WRITE, 8'hFF);
        send_op(OP_HOST_WRITE, 8'h5A);
        send_op(OP_TX_READY, 8'h00);
        send_status(OP_MODEM_STAT, 8'h00);
        send_op(OP_HOST_READ, 8'h00);
        send_status(OP_MODEM_STAT, MSR_READY);
        send_status(OP_LINE_STAT, LSR_ERRORS);
        send_op(OP_HOST_READ, 8'h00);
        // Both error kinds pending: the modem error must win.
        send_status(OP_MODEM_STAT, ~MSR_READY);
        send_op(OP_HOST_READ, 8'h00);
        send_status(OP_MODEM_STAT, 8'hFF);
        send_status(OP_LINE_STAT, ~LSR_ERRORS);
        send_op(OP_RX_BYTE, 8'h3C);
        send_op(OP_HOST_READ, 8'h00);
        send_beat(OP_UNUSED, 8'hFF, 8'hFF);
        send_op(OP_RX_BYTE, 8'h11);
        send_op(OP_HOST_WRITE, 8'h22);
        send_op(OP_CLEAR, 8'h00);
        send_op(OP_HOST_READ, 8'h00);
        send_op(OP_TX_READY, 8'h00);

        // Burst above the limit: forty queued bytes leave in clamped bursts, then idle.
        set_burst(5'd31);
        repeat (40) send_op(OP_HOST_WRITE, 8'($urandom));
        repeat (4) send_op(OP_TX_READY, 8'h00);

        // Random phases over several burst settings.
        set_burst(5'd1);
        run_random(48);
        set_burst(5'd0);
        run_random(48);
        set_burst(5'd17);
        run_random(48);
        set_burst(BURST_W'($urandom_range(2, 15)));
        run_random(48);
        set_burst(5'd16);
        run_random(48);

        drain();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/ubps_pkg.sv
rtl/ubps_ram.sv
rtl/ubps_ptr_unit.sv
rtl/uart_buffered_port_service.sv
tb/sv/uart_buffered_port_service_tb.sv
